[design/pcc_pkg.sv]
// Shared types and constants for the pupil clamp-to-circle block.
`default_nettype none

package pcc_pkg;

  // Radius registers and the travel distance derived from them
  localparam int RADIUS_BITS = 10;

  // Offset magnitude never exceeds the travel distance, so the divider
  // only has to produce this many quotient bits
  localparam int QUOT_BITS = RADIUS_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_RADIUS   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PUPIL_RADIUS = CFG_INDEX_BITS'(1);

  localparam logic [RADIUS_BITS-1:0] EYE_RADIUS_RESET   = RADIUS_BITS'(90);
  localparam logic [RADIUS_BITS-1:0] PUPIL_RADIUS_RESET = RADIUS_BITS'(47);

  // Control bits that travel with each request down the cell chain
  typedef struct packed {
    logic valid;
    logic in_circle; // target strictly inside the travel circle
    logic neg_x;     // dx is negative
    logic neg_y;     // dy is negative
    logic zero_len;  // root came out zero, offsets are zero
  } pcc_ctl_t;

endpackage

`default_nettype wire

[design/pcc_root_cell.sv]
// One cell of the square-root chain: retires one root bit per cycle while adv is high.
`default_nettype none

module pcc_root_cell #(
  parameter int ROOT_BITS = 33,
  parameter int SIDE_W    = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  pcc_pkg::pcc_ctl_t      ctl_in,
  input  logic [2*ROOT_BITS-1:0] rad_in,
  input  logic [ROOT_BITS:0]     rem_in,
  input  logic [ROOT_BITS-1:0]   root_in,
  input  logic [SIDE_W-1:0]      side_in,
  output pcc_pkg::pcc_ctl_t      ctl_out,
  output logic [2*ROOT_BITS-1:0] rad_out,
  output logic [ROOT_BITS:0]     rem_out,
  output logic [ROOT_BITS-1:0]   root_out,
  output logic [SIDE_W-1:0]      side_out
);
  import pcc_pkg::*;

  localparam int TW = ROOT_BITS + 3;

  logic [TW-1:0] rem_sh;
  logic [TW-1:0] trial;
  logic [TW-1:0] rem_sub;
  logic          take;

  // Bring down the next bit pair and try 4*root+1
  always_comb begin
    rem_sh  = {rem_in, rad_in[2*ROOT_BITS-1 -: 2]};
    trial   = TW'({root_in, 2'b01});
    take    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  // Payload registers; remainder stays below 2*root+1, so ROOT_BITS+1 bits hold it
  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out  <= rad_in << 2;
      rem_out  <= take ? rem_sub[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
      root_out <= {root_in[ROOT_BITS-2:0], take};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

[design/pcc_div_cell.sv]
// One cell of the divider chain: one quotient bit per cycle for both axes while adv is high.
`default_nettype none

module pcc_div_cell #(
  parameter int DW     = 35,
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  pcc_pkg::pcc_ctl_t              ctl_in,
  input  logic [DW-1:0]                  div_in,
  input  logic [DW-1:0]                  rem_x_in,
  input  logic [DW-1:0]                  rem_y_in,
  input  logic [pcc_pkg::QUOT_BITS-1:0]  q_x_in,
  input  logic [pcc_pkg::QUOT_BITS-1:0]  q_y_in,
  input  logic [SIDE_W-1:0]              side_in,
  output pcc_pkg::pcc_ctl_t              ctl_out,
  output logic [DW-1:0]                  div_out,
  output logic [DW-1:0]                  rem_x_out,
  output logic [DW-1:0]                  rem_y_out,
  output logic [pcc_pkg::QUOT_BITS-1:0]  q_x_out,
  output logic [pcc_pkg::QUOT_BITS-1:0]  q_y_out,
  output logic [SIDE_W-1:0]              side_out
);
  import pcc_pkg::*;

  logic take_x;
  logic take_y;

  // Restoring step against the shifted divisor, shared by both lanes
  always_comb begin
    take_x = (rem_x_in >= div_in);
    take_y = (rem_y_in >= div_in);
  end

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      div_out   <= div_in >> 1;
      rem_x_out <= take_x ? (rem_x_in - div_in) : rem_x_in;
      rem_y_out <= take_y ? (rem_y_in - div_in) : rem_y_in;
      q_x_out   <= {q_x_in[QUOT_BITS-2:0], take_x};
      q_y_out   <= {q_y_in[QUOT_BITS-2:0], take_y};
      side_out  <= side_in;
    end
  end

endmodule

`default_nettype wire

[design/pupil_clamp_to_circle_unit.sv]
// Pupil clamp-to-circle unit: front end, root and divider cell chains, output skid.
`default_nettype none

// Places a pupil centre for an eye centre and a target point. The pupil may move
// up to travel = eye_radius - pupil_radius (zero when the pupil is not smaller);
// a target strictly inside that circle is used as is (on_target = 1), otherwise
// the pupil sits on the ray toward the target at distance travel, each offset
// floored, and the result saturates to the coordinate range. The datapath is a
// straight pipeline: three front stages (difference, squares and products, sum
// and compare), a chain of COORD_BITS+1+ROOT_FRAC_BITS root cells retiring one
// root bit each, a chain of 10 divider cells retiring one quotient bit each for
// both axes, and the output register. One request is taken every clock while the
// skid stage is empty; the request passes COORD_BITS+ROOT_FRAC_BITS+15 register
// stages before its result is presented. A one-entry skid stage behind the output
// register absorbs output back-pressure, and the whole pipeline holds while that
// stage is full.
// Radius registers are written through cfg_write/cfg_index/cfg_data; writes to
// unknown indexes are dropped.
module pupil_clamp_to_circle_unit #(
  parameter int COORD_BITS     = 16,
  parameter int ROOT_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pcc_pkg::RADIUS_BITS-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         eye_x,
  input  logic signed [COORD_BITS-1:0]         eye_y,
  input  logic signed [COORD_BITS-1:0]         target_x,
  input  logic signed [COORD_BITS-1:0]         target_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         pupil_x,
  output logic signed [COORD_BITS-1:0]         pupil_y,
  output logic                                 on_target
);
  import pcc_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int F      = ROOT_FRAC_BITS;
  localparam int AW     = C + 1;                 // |d| width
  localparam int D2W    = 2 * AW;                // dx^2 + dy^2 width
  localparam int TTW    = 2 * RADIUS_BITS;       // travel^2 width
  localparam int CW     = (D2W > TTW) ? D2W : TTW;
  localparam int RB     = C + 1 + F;             // root width
  localparam int RADW   = 2 * RB;                // radicand width
  localparam int PW     = AW + RADIUS_BITS;      // |d| * travel width
  localparam int NB     = PW + F;                // dividend width
  localparam int DW     = NB;                    // divider datapath width
  localparam int SIDE_R = 4 * C + 2 * NB;
  localparam int SIDE_D = 4 * C;
  localparam int OW     = QUOT_BITS + 1;         // floored offset magnitude
  localparam int SW     = ((C > OW + 1) ? C : OW + 1) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [RADIUS_BITS-1:0] eye_radius;
  logic [RADIUS_BITS-1:0] pupil_radius;
  logic [RADIUS_BITS-1:0] travel_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_radius   <= EYE_RADIUS_RESET;
      pupil_radius <= PUPIL_RADIUS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EYE_RADIUS:   eye_radius   <= cfg_data;
        REG_PUPIL_RADIUS: pupil_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign travel_now = (eye_radius > pupil_radius) ? (eye_radius - pupil_radius) : '0;

  // Pipeline advances unless the skid stage holds a result
  logic adv;
  logic skid_valid;

  assign adv      = ~skid_valid;
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: differences and magnitudes
  logic signed [AW-1:0] dx_now, dy_now;
  logic [AW-1:0]        ax_now, ay_now;

  always_comb begin
    dx_now = AW'(target_x) - AW'(eye_x);
    dy_now = AW'(target_y) - AW'(eye_y);
    ax_now = dx_now[AW-1] ? AW'(-dx_now) : AW'(dx_now);
    ay_now = dy_now[AW-1] ? AW'(-dy_now) : AW'(dy_now);
  end

  pcc_ctl_t               s1_ctl;
  logic [C-1:0]           s1_ex, s1_ey, s1_tx, s1_ty;
  logic [AW-1:0]          s1_ax, s1_ay;
  logic [RADIUS_BITS-1:0] s1_travel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= '{valid: in_valid, in_circle: 1'b0, neg_x: dx_now[AW-1],
                  neg_y: dy_now[AW-1], zero_len: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ex     <= eye_x;
      s1_ey     <= eye_y;
      s1_tx     <= target_x;
      s1_ty     <= target_y;
      s1_ax     <= ax_now;
      s1_ay     <= ay_now;
      s1_travel <= travel_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares and products
  pcc_ctl_t      s2_ctl;
  logic [C-1:0]  s2_ex, s2_ey, s2_tx, s2_ty;
  logic [D2W-1:0] s2_sx, s2_sy;
  logic [TTW-1:0] s2_tt;
  logic [PW-1:0]  s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ex <= s1_ex;
      s2_ey <= s1_ey;
      s2_tx <= s1_tx;
      s2_ty <= s1_ty;
      s2_sx <= s1_ax * s1_ax;
      s2_sy <= s1_ay * s1_ay;
      s2_tt <= s1_travel * s1_travel;
      s2_px <= s1_ax * s1_travel;
      s2_py <= s1_ay * s1_travel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance, inside test, radicand and dividends
  logic [D2W-1:0] d2_now;
  pcc_ctl_t       s3_ctl_next;

  always_comb begin
    d2_now                = s2_sx + s2_sy;
    s3_ctl_next           = s2_ctl;
    s3_ctl_next.in_circle = (CW'(d2_now) < CW'(s2_tt));
  end

  pcc_ctl_t        s3_ctl;
  logic [C-1:0]    s3_ex, s3_ey, s3_tx, s3_ty;
  logic [RADW-1:0] s3_rad;
  logic [NB-1:0]   s3_nx, s3_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else if (adv) begin
      s3_ctl <= s3_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ex  <= s2_ex;
      s3_ey  <= s2_ey;
      s3_tx  <= s2_tx;
      s3_ty  <= s2_ty;
      s3_rad <= RADW'(d2_now) << (2 * F);
      s3_nx  <= NB'(s2_px) << F;
      s3_ny  <= NB'(s2_py) << F;
    end
  end

  // ---------------------------------------------------------------------------
  // Square-root chain
  pcc_ctl_t          r_ctl  [RB+1];
  logic [RADW-1:0]   r_rad  [RB+1];
  logic [RB:0]       r_rem  [RB+1];
  logic [RB-1:0]     r_root [RB+1];
  logic [SIDE_R-1:0] r_side [RB+1];

  assign r_ctl[0]  = s3_ctl;
  assign r_rad[0]  = s3_rad;
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_side[0] = {s3_ex, s3_ey, s3_tx, s3_ty, s3_nx, s3_ny};

  for (genvar k = 0; k < RB; k++) begin : g_root
    pcc_root_cell #(
      .ROOT_BITS (RB),
      .SIDE_W    (SIDE_R)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (r_ctl[k]),
      .rad_in   (r_rad[k]),
      .rem_in   (r_rem[k]),
      .root_in  (r_root[k]),
      .side_in  (r_side[k]),
      .ctl_out  (r_ctl[k+1]),
      .rad_out  (r_rad[k+1]),
      .rem_out  (r_rem[k+1]),
      .root_out (r_root[k+1]),
      .side_out (r_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Divider chain
  logic [C-1:0]  rt_ex, rt_ey, rt_tx, rt_ty;
  logic [NB-1:0] rt_nx, rt_ny;

  assign {rt_ex, rt_ey, rt_tx, rt_ty, rt_nx, rt_ny} = r_side[RB];

  pcc_ctl_t           d_ctl  [QUOT_BITS+1];
  logic [DW-1:0]      d_div  [QUOT_BITS+1];
  logic [DW-1:0]      d_remx [QUOT_BITS+1];
  logic [DW-1:0]      d_remy [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] d_qx [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] d_qy [QUOT_BITS+1];
  logic [SIDE_D-1:0]  d_side [QUOT_BITS+1];

  always_comb begin
    d_ctl[0]          = r_ctl[RB];
    d_ctl[0].zero_len = (r_root[RB] == '0);
  end

  assign d_div[0]  = DW'(r_root[RB]) << (QUOT_BITS - 1);
  assign d_remx[0] = rt_nx;
  assign d_remy[0] = rt_ny;
  assign d_qx[0]   = '0;
  assign d_qy[0]   = '0;
  assign d_side[0] = {rt_ex, rt_ey, rt_tx, rt_ty};

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    pcc_div_cell #(
      .DW     (DW),
      .SIDE_W (SIDE_D)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .ctl_in    (d_ctl[j]),
      .div_in    (d_div[j]),
      .rem_x_in  (d_remx[j]),
      .rem_y_in  (d_remy[j]),
      .q_x_in    (d_qx[j]),
      .q_y_in    (d_qy[j]),
      .side_in   (d_side[j]),
      .ctl_out   (d_ctl[j+1]),
      .div_out   (d_div[j+1]),
      .rem_x_out (d_remx[j+1]),
      .rem_y_out (d_remy[j+1]),
      .q_x_out   (d_qx[j+1]),
      .q_y_out   (d_qy[j+1]),
      .side_out  (d_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Finish: floor for negative offsets, add to centre, saturate, select
  pcc_ctl_t             fin_ctl;
  logic [C-1:0]         fin_ex, fin_ey, fin_tx, fin_ty;
  logic [OW-1:0]        mag_x, mag_y;
  logic signed [OW:0]   off_x, off_y;
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 ovf_x, ovf_y;
  logic [C-1:0]         fin_px, fin_py;

  assign fin_ctl = d_ctl[QUOT_BITS];
  assign {fin_ex, fin_ey, fin_tx, fin_ty} = d_side[QUOT_BITS];

  always_comb begin
    // Inexact quotient of a negative dividend rounds one further down
    mag_x = OW'(d_qx[QUOT_BITS]) + OW'(fin_ctl.neg_x & (|d_remx[QUOT_BITS]));
    mag_y = OW'(d_qy[QUOT_BITS]) + OW'(fin_ctl.neg_y & (|d_remy[QUOT_BITS]));
    if (fin_ctl.zero_len) begin
      mag_x = '0;
      mag_y = '0;
    end
    off_x = fin_ctl.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    off_y = fin_ctl.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    sum_x = SW'($signed(fin_ex)) + SW'(off_x);
    sum_y = SW'($signed(fin_ey)) + SW'(off_y);
    // Fits when all bits from the sign bit of the range upward agree
    ovf_x = !((&sum_x[SW-1:C-1]) || !(|sum_x[SW-1:C-1]));
    ovf_y = !((&sum_y[SW-1:C-1]) || !(|sum_y[SW-1:C-1]));
    if (fin_ctl.in_circle) begin
      fin_px = fin_tx;
      fin_py = fin_ty;
    end else begin
      fin_px = ovf_x ? {sum_x[SW-1], {(C-1){~sum_x[SW-1]}}} : sum_x[C-1:0];
      fin_py = ovf_y ? {sum_y[SW-1], {(C-1){~sum_y[SW-1]}}} : sum_y[C-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid stage
  logic [C-1:0] skid_x, skid_y;
  logic         skid_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_ctl.valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        pupil_x   <= skid_x;
        pupil_y   <= skid_y;
        on_target <= skid_on;
      end
    end else if (fin_ctl.valid) begin
      if (!out_valid || out_ready) begin
        pupil_x   <= fin_px;
        pupil_y   <= fin_py;
        on_target <= fin_ctl.in_circle;
      end else begin
        skid_x  <= fin_px;
        skid_y  <= fin_py;
        skid_on <= fin_ctl.in_circle;
      end
    end
  end

endmodule

`default_nettype wire

[sim/tb_pupil_clamp_to_circle_unit.sv]
// Self-checking testbench for the pupil clamp-to-circle unit.
module tb_pupil_clamp_to_circle_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int COORD_BITS     = 16;
  localparam int ROOT_FRAC_BITS = 8;
  localparam int LATENCY        = COORD_BITS + ROOT_FRAC_BITS + 15;
  localparam int MAX_WAIT       = 10;
  localparam int RADIUS_PHASES  = 12;
  localparam int REQS_PER_PHASE = 140;
  localparam int RADIUS_MAX     = (1 << RADIUS_BITS) - 1;
  localparam int INDEX_MAX      = (1 << CFG_INDEX_BITS) - 1;
  localparam int FIRST_SPARE_INDEX = int'(REG_PUPIL_RADIUS) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [RADIUS_BITS-1:0]       radius_t;
  typedef logic [CFG_INDEX_BITS-1:0]    reg_index_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    coord_t x;
    coord_t y;
    logic   on_target;
  } pupil_t;

  // Predicts the pupil position per request and checks results in order
  class pupil_scoreboard;
    radius_t eye_r;
    radius_t pupil_r;
    pupil_t  pending_pupils[$];
    int      failures;

    function new();
      eye_r    = EYE_RADIUS_RESET;
      pupil_r  = PUPIL_RADIUS_RESET;
      failures = 0;
    endfunction

    // Mirror of the radius registers; spare indexes are dropped
    function void set_radius(reg_index_t idx, radius_t val);
      case (idx)
        REG_EYE_RADIUS: begin
          eye_r = val;
        end
        REG_PUPIL_RADIUS: begin
          pupil_r = val;
        end
        default: begin
        end
      endcase
    endfunction

    function int travel();
      return (eye_r > pupil_r) ? int'(eye_r) - int'(pupil_r) : 0;
    endfunction

    // Bitwise integer square root, two bits per step
    static function longint sqrt_floor(longint v);
      longint root;
      longint rest;
      longint trial;
      root = 0;
      rest = 0;
      for (int p = 62; p >= 0; p -= 2) begin
        rest  = (rest << 2) | ((v >> p) & 64'd3);
        trial = (root << 2) | 64'd1;
        if (rest >= trial) begin
          rest = rest - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    // Quotient rounded toward minus infinity (den is always positive here)
    static function longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if (num < 0 && q * den != num)
        q = q - 1;
      return q;
    endfunction

    static function coord_t clamp_coord(longint v);
      if (v > longint'(COORD_MAX))
        return COORD_MAX;
      if (v < longint'(COORD_MIN))
        return COORD_MIN;
      return coord_t'(v);
    endfunction

    function pupil_t place_pupil(coord_t ex, coord_t ey, coord_t tx, coord_t ty);
      pupil_t p;
      longint dx;
      longint dy;
      longint d2;
      longint reach;
      longint len;
      longint scale;
      longint ox;
      longint oy;
      dx    = longint'(tx) - longint'(ex);
      dy    = longint'(ty) - longint'(ey);
      d2    = dx * dx + dy * dy;
      reach = longint'(travel());
      if (d2 < reach * reach) begin
        p.x         = tx;
        p.y         = ty;
        p.on_target = 1'b1;
      end else begin
        // Root carries ROOT_FRAC_BITS fraction bits; zero root leaves the pupil centered
        len = sqrt_floor(d2 << (2 * ROOT_FRAC_BITS));
        ox  = 0;
        oy  = 0;
        if (len != 0) begin
          scale = reach << ROOT_FRAC_BITS;
          ox    = floor_quot(dx * scale, len);
          oy    = floor_quot(dy * scale, len);
        end
        p.x         = clamp_coord(longint'(ex) + ox);
        p.y         = clamp_coord(longint'(ey) + oy);
        p.on_target = 1'b0;
      end
      return p;
    endfunction

    function void note_request(coord_t ex, coord_t ey, coord_t tx, coord_t ty);
      pending_pupils.push_back(place_pupil(ex, ey, tx, ty));
    endfunction

    function void check_result(coord_t px, coord_t py, logic hit);
      pupil_t want;
      if (pending_pupils.size() == 0) begin
        $error("unexpected result: pupil_x=%0d pupil_y=%0d on_target=%0b", px, py, hit);
        failures++;
        return;
      end
      want = pending_pupils.pop_front();
      if (px !== want.x) begin
        $error("pupil_x: expected %0d, got %0d", want.x, px);
        failures++;
      end
      if (py !== want.y) begin
        $error("pupil_y: expected %0d, got %0d", want.y, py);
        failures++;
      end
      if (hit !== want.on_target) begin
        $error("on_target: expected %0b, got %0b", want.on_target, hit);
        failures++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  reg_index_t cfg_index = '0;
  radius_t    cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  coord_t     eye_x     = '0;
  coord_t     eye_y     = '0;
  coord_t     target_x  = '0;
  coord_t     target_y  = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  coord_t     pupil_x;
  coord_t     pupil_y;
  logic       on_target;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_stall  = 0;

  pupil_scoreboard board = new();

  pupil_clamp_to_circle_unit #(
    .COORD_BITS    (COORD_BITS),
    .ROOT_FRAC_BITS(ROOT_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .eye_x    (eye_x),
    .eye_y    (eye_y),
    .target_x (target_x),
    .target_y (target_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pupil_x  (pupil_x),
    .pupil_y  (pupil_y),
    .on_target(on_target)
  );

  always #1 clk = ~clk;

  // Result side: check each accepted result, then stall a random number of cycles
  always @(posedge clk) begin : result_sink
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else if (out_valid && out_ready) begin
      board.check_result(pupil_x, pupil_y, on_target);
      hold = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold != 0) begin
        out_ready <= 1'b0;
        rx_stall  <= hold;
      end
    end else if (!out_ready) begin
      if (rx_stall <= 1)
        out_ready <= 1'b1;
      rx_stall <= rx_stall - 1;
    end
  end

  // One register write; cfg_write is dropped again before the task returns
  task automatic write_radius(reg_index_t idx, radius_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_radius(idx, val);
    @(posedge clk);
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(coord_t ex, coord_t ey, coord_t tx, coord_t ty);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    eye_x    <= ex;
    eye_y    <= ey;
    target_x <= tx;
    target_y <= ty;
    do
      @(posedge clk);
    while (!in_ready);
    board.note_request(ex, ey, tx, ty);
  endtask

  // Random request, mostly with the target near the travel circle
  task automatic random_request();
    int     span;
    int     reach;
    int     d;
    coord_t ex;
    coord_t ey;
    coord_t tx;
    coord_t ty;
    span  = board.travel();
    reach = 2 * span + 2;
    ex    = coord_t'($urandom);
    ey    = coord_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        tx = ex + coord_t'(int'($urandom_range(0, 2 * reach)) - reach);
        ty = ey + coord_t'(int'($urandom_range(0, 2 * reach)) - reach);
      end
      5: begin
        // on or next to the circle along an axis
        d = span + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1))
          d = -d;
        if ($urandom_range(0, 1)) begin
          tx = ex + coord_t'(d);
          ty = ey;
        end else begin
          tx = ex;
          ty = ey + coord_t'(d);
        end
      end
      6: begin
        // eye near the coordinate limits, target at a limit
        ex = $urandom_range(0, 1) ? COORD_MAX - coord_t'($urandom_range(0, reach))
                                  : COORD_MIN + coord_t'($urandom_range(0, reach));
        ey = $urandom_range(0, 1) ? COORD_MAX - coord_t'($urandom_range(0, reach))
                                  : COORD_MIN + coord_t'($urandom_range(0, reach));
        tx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        ty = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
      7, 8: begin
        tx = coord_t'($urandom);
        ty = coord_t'($urandom);
      end
      default: begin
        tx = ex;
        ty = ey;
      end
    endcase
    send_request(ex, ey, tx, ty);
  endtask

  // Wait until every noted request has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_pupils.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    radius_t er;
    radius_t pr;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset radii (travel 43)
    send_request(0, 0, 0, 0);
    send_request(0, 0, 42, 0);
    send_request(0, 0, 43, 0);
    send_request(0, 0, -43, 0);
    send_request(0, 0, 0, -43);
    send_request(0, 0, 30, 30);
    send_request(0, 0, 31, 31);
    send_request(0, 0, -50, -7);
    send_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_request(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_request(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    send_request(COORD_MAX, COORD_MAX, COORD_MAX - 100, COORD_MAX);
    send_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN + 44);
    send_request(1000, 1000, 1000, -31000);
    drain();

    // Pupil larger than the eye: zero travel
    write_radius(REG_EYE_RADIUS, 47);
    write_radius(REG_PUPIL_RADIUS, 90);
    send_request(0, 0, 0, 0);
    send_request(123, -456, 123, -456);
    send_request(5, 5, 6, 5);
    send_request(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    drain();

    // Random traffic over a range of radius settings
    for (int ph = 0; ph < RADIUS_PHASES; ph++) begin
      case (ph)
        0: begin
          er = 0;
          pr = 0;
        end
        1: begin
          er = RADIUS_MAX;
          pr = 0;
        end
        2: begin
          er = 0;
          pr = RADIUS_MAX;
        end
        3: begin
          er = RADIUS_MAX;
          pr = RADIUS_MAX;
        end
        4: begin
          er = 1;
          pr = 0;
        end
        default: begin
          er = $urandom_range(0, RADIUS_MAX);
          pr = ($urandom_range(0, 3) == 0) ? $urandom_range(er, RADIUS_MAX)
                                           : $urandom_range(0, er);
        end
      endcase
      write_radius(REG_EYE_RADIUS, er);
      write_radius(REG_PUPIL_RADIUS, pr);
      // a write to a spare index must leave both radii alone
      write_radius(reg_index_t'($urandom_range(FIRST_SPARE_INDEX, INDEX_MAX)),
                   radius_t'($urandom));
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 4 == 2);
      repeat (REQS_PER_PHASE) random_request();
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (board.failures == 0 && board.pending_pupils.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
